>>> hw/rtl/blpl_pkg.sv
`timescale 1ns / 1ps
// blpl_pkg: shared types and constants of the black-point levels unit
// no dependencies; used by blpl_table_fill and black_point_levels_unit

package blpl_pkg;

	// full scale of a channel in 65280ths (255 * 256)
	localparam logic [15:0] LVL_FULL     = 16'd65280;
	// black level step per weight unit, input mode
	localparam logic [6:0]  LVL_IN_STEP  = 7'd102;
	// gain loss per weight unit, output mode
	localparam logic [6:0]  LVL_OUT_STEP = 7'd100;
	// floor lift per weight unit, output mode
	localparam logic [14:0] LVL_OUT_LIFT = 15'd25500;

	// one write into the channel lookup tables
	typedef struct packed {
		logic       en;
		logic [7:0] addr;
		logic [7:0] data;
	} blpl_wr_t;

endpackage

>>> hw/rtl/blpl_pix_if.sv
`timescale 1ns / 1ps
// blpl_in_if and blpl_out_if: valid/ready pixel channels of the levels unit
// no dependencies

interface blpl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic [7:0] alpha_in;
	logic       last_pixel_in;

	modport source (
		output valid, red_in, green_in, blue_in, alpha_in, last_pixel_in,
		input  ready
	);
	modport sink (
		input  valid, red_in, green_in, blue_in, alpha_in, last_pixel_in,
		output ready
	);
endinterface

interface blpl_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [7:0] alpha_out;
	logic       last_pixel_out;

	modport source (
		output valid, red_out, green_out, blue_out, alpha_out, last_pixel_out,
		input  ready
	);
	modport sink (
		input  valid, red_out, green_out, blue_out, alpha_out, last_pixel_out,
		output ready
	);
endinterface

>>> hw/rtl/blpl_table_fill.sv
`timescale 1ns / 1ps
// blpl_table_fill: computes the 256-entry channel lookup table for one weight
// one restoring division per entry; depends on blpl_pkg

module blpl_table_fill
	import blpl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              restart,
	input  logic signed [9:0] weight,
	output logic              busy,
	output blpl_wr_t          wr
);

	typedef enum logic [2:0] {
		FS_SETUP = 3'b001,
		FS_DIV   = 3'b010,
		FS_IDLE  = 3'b100
	} fill_state_t;

	fill_state_t state_q;
	logic [7:0]  addr_q;
	logic [2:0]  bit_q;
	logic [23:0] rem_q;
	logic [15:0] den_q;
	logic [7:0]  quot_q;

	logic [8:0]  pos_a;
	logic [9:0]  neg_a;
	logic [15:0] m_lvl;
	logic [15:0] s_lvl;
	logic [15:0] x_lvl;
	logic [15:0] gain;
	logic [23:0] n_calc;
	logic [15:0] d_calc;
	logic [23:0] shifted;
	logic        fits;
	logic [7:0]  quot_next;

	// numerator and divisor of the current entry
	assign pos_a = weight[8:0];
	assign neg_a = 10'(-weight);
	assign m_lvl = 16'(16'(pos_a) * 16'(LVL_IN_STEP));
	assign s_lvl = {addr_q, 8'h00};
	assign x_lvl = (s_lvl > m_lvl) ? (s_lvl - m_lvl) : '0;
	assign gain  = LVL_FULL - 16'(16'(neg_a) * 16'(LVL_OUT_STEP));

	always_comb begin
		if (weight == '0) begin
			n_calc = 24'(addr_q);
			d_calc = 16'd1;
		end else if (weight[9]) begin
			// bounded by 255 * 65280, fits 24 bits
			n_calc = 24'(24'(addr_q) * 24'(gain)) + 24'(24'(neg_a) * 24'(LVL_OUT_LIFT));
			d_calc = LVL_FULL;
		end else begin
			// times 255 as times 256 minus one
			n_calc = {x_lvl, 8'h00} - 24'(x_lvl);
			d_calc = LVL_FULL - m_lvl;
		end
	end

	// one quotient bit per cycle, msb first
	assign shifted   = 24'(den_q) << bit_q;
	assign fits      = (rem_q >= shifted);
	assign quot_next = quot_q | (8'(fits) << bit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_SETUP;
			addr_q  <= '0;
			bit_q   <= '0;
		end else if (restart) begin
			state_q <= FS_SETUP;
			addr_q  <= '0;
		end else begin
			case (state_q)
				FS_SETUP: begin
					bit_q   <= 3'd7;
					state_q <= FS_DIV;
				end
				FS_DIV: begin
					bit_q <= bit_q - 3'd1;
					if (bit_q == '0) begin
						addr_q  <= addr_q + 8'd1;
						state_q <= (addr_q == 8'hFF) ? FS_IDLE : FS_SETUP;
					end
				end
				FS_IDLE: begin
					state_q <= FS_IDLE;
				end
				default: begin
					state_q <= FS_SETUP;
					addr_q  <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FS_SETUP) begin
			rem_q  <= n_calc;
			den_q  <= d_calc;
			quot_q <= '0;
		end else if (state_q == FS_DIV) begin
			quot_q <= quot_next;
			if (fits) begin
				rem_q <= rem_q - shifted;
			end
		end
	end

	assign busy    = (state_q != FS_IDLE);
	assign wr.en   = (state_q == FS_DIV) && (bit_q == '0) && !restart;
	assign wr.addr = addr_q;
	assign wr.data = quot_next;

endmodule

>>> hw/rtl/black_point_levels_unit.sv
`timescale 1ns / 1ps
// black_point_levels_unit: black-point levels adjustment on an RGBA8 pixel stream
// depends on blpl_pkg, blpl_in_if / blpl_out_if and blpl_table_fill
//
//  channel    kind         direction  word
//  pixels     valid/ready  into unit  red_in, green_in, blue_in, alpha_in, last_pixel_in
//  adjusted   valid/ready  out        red_out, green_out, blue_out, alpha_out, last_pixel_out
//  cfg        write only   into unit  cfg_wdata = weight_level, taken when cfg_we
//
// one pixel per clock while not rebuilding or stalled, through two register stages:
// an accepted word enters the read stage, then the result register that drives adjusted;
// the three table read ports (two on one copy, one on the other) serve red, green and blue
// after reset and after every weight write the tables are rebuilt: 256 entries, each
// a setup step plus 8 divide steps, with pixels.ready low throughout the rebuild
// a stall on adjusted holds the result register, then the read stage, then ready

module black_point_levels_unit
	import blpl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	blpl_in_if.sink          pixels,
	blpl_out_if.source       adjusted,
	input  logic             cfg_we,
	input  logic [9:0]       cfg_wdata
);

	// weight register, signed 1/256 units
	logic signed [9:0] weight_q;

	// table builder
	logic     fill_busy;
	blpl_wr_t wr;

	// two copies of the channel table: red and green read copy a, blue reads copy b
	logic [7:0] lut_a [256];
	logic [7:0] lut_b [256];

	// read stage
	logic       valid_s1;
	logic [7:0] red_s1;
	logic [7:0] green_s1;
	logic [7:0] blue_s1;
	logic [7:0] alpha_s1;
	logic       last_s1;

	// result register
	logic       out_valid_q;
	logic [7:0] red_q;
	logic [7:0] green_q;
	logic [7:0] blue_q;
	logic [7:0] alpha_q;
	logic       last_q;

	logic advance;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= '0;
		end else if (cfg_we) begin
			weight_q <= cfg_wdata;
		end
	end

	blpl_table_fill u_fill (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_we),
		.weight  (weight_q),
		.busy    (fill_busy),
		.wr      (wr)
	);

	// result register frees up when empty or being taken
	assign advance = !out_valid_q || adjusted.ready;
	// read stage takes a pixel when empty or moving on, never during a rebuild
	assign pixels.ready = !fill_busy && (!valid_s1 || advance);
	assign take = pixels.valid && pixels.ready;

	// table memories: one write port, registered reads
	always_ff @(posedge clk) begin
		if (wr.en) begin
			lut_a[wr.addr] <= wr.data;
			lut_b[wr.addr] <= wr.data;
		end
		if (take) begin
			red_s1   <= lut_a[pixels.red_in];
			green_s1 <= lut_a[pixels.green_in];
			blue_s1  <= lut_b[pixels.blue_in];
			alpha_s1 <= pixels.alpha_in;
			last_s1  <= pixels.last_pixel_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// result payload loads when the read stage moves on
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			red_q   <= red_s1;
			green_q <= green_s1;
			blue_q  <= blue_s1;
			alpha_q <= alpha_s1;
			last_q  <= last_s1;
		end
	end

	assign adjusted.valid          = out_valid_q;
	assign adjusted.red_out        = red_q;
	assign adjusted.green_out      = green_q;
	assign adjusted.blue_out       = blue_q;
	assign adjusted.alpha_out      = alpha_q;
	assign adjusted.last_pixel_out = last_q;

`ifndef SYNTH
	// a table write never coincides with a pixel read
	a_no_read_while_fill: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> !take)
		else $error("table written while a pixel was read");

	// a weight write always starts a rebuild
	a_cfg_starts_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> fill_busy)
		else $error("weight write did not start a table rebuild");

	// a pixel stuck in the read stage keeps its words
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(red_s1) && $stable(alpha_s1)))
		else $error("read stage lost its pixel during a stall");
`endif

endmodule

>>> sim/black_point_levels_unit_test.sv
`timescale 1ns / 1ps
// black_point_levels_unit_test: self-checking bench for the black-point levels unit
// depends on blpl_in_if / blpl_out_if and black_point_levels_unit

// one pixel word as the bench sees it on either channel
typedef struct packed {
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	logic       last_pixel;
} pix_word_t;

// predicts the adjusted pixel for every accepted input word and checks results in order
class blpl_levels_sb;
	logic signed [9:0] weight;
	pix_word_t         expected_q[$];
	int unsigned       mismatch_cnt;

	function new();
		weight       = '0;
		mismatch_cnt = 0;
	endfunction

	// black-point adjustment of one channel at the current weight
	function automatic logic [7:0] level_channel(logic [7:0] c);
		int w;
		int a;
		int m;
		int s;
		int num;
		int r;
		w = weight;
		s = int'(c) * 256;
		if (w == 0) begin
			return c;
		end
		if (w > 0) begin
			// input mode: raise the input black level to m
			a   = w;
			m   = 102 * a;
			num = (s > m) ? (s - m) : 0;
			r   = (num * 255) / (65280 - m);
		end else begin
			// output mode: compress the span and lift the floor
			a = -w;
			r = (int'(c) * (65280 - 100 * a) + 25500 * a) / 65280;
		end
		if (r > 255) begin
			r = 255;
		end
		return r[7:0];
	endfunction

	function void note_pixel(pix_word_t p);
		pix_word_t e;
		e.red        = level_channel(p.red);
		e.green      = level_channel(p.green);
		e.blue       = level_channel(p.blue);
		e.alpha      = p.alpha;
		e.last_pixel = p.last_pixel;
		expected_q.push_back(e);
	endfunction

	task report_mismatch(string what, int got, int want);
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_cnt++;
	endtask

	task check_pixel(pix_word_t got);
		pix_word_t e;
		if (expected_q.size() == 0) begin
			report_mismatch("unexpected word", 1, 0);
			return;
		end
		e = expected_q.pop_front();
		if (got.red !== e.red) begin
			report_mismatch("red_out", got.red, e.red);
		end
		if (got.green !== e.green) begin
			report_mismatch("green_out", got.green, e.green);
		end
		if (got.blue !== e.blue) begin
			report_mismatch("blue_out", got.blue, e.blue);
		end
		if (got.alpha !== e.alpha) begin
			report_mismatch("alpha_out", got.alpha, e.alpha);
		end
		if (got.last_pixel !== e.last_pixel) begin
			report_mismatch("last_pixel_out", got.last_pixel, e.last_pixel);
		end
	endtask
endclass

module black_point_levels_unit_test;

	// a table rebuild per weight write, fourteen writes, and
	// 2000 words each waiting out an idle gap plus a stall burst: far below this
	localparam int unsigned CYCLE_LIMIT   = 600000;
	localparam int          PHASE_WORDS   = 200;
	localparam int          RAND_PHASES   = 10;
	localparam int          DRAIN_CYCLES  = 20;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [9:0]        cfg_wdata;

	blpl_in_if         pixels();
	blpl_out_if        adjusted();

	blpl_levels_sb     sb;

	// idling switches, cleared for the last phase
	bit                src_idle_en;
	bit                snk_idle_en;
	// long receiver hold asked for by the stimulus, in cycles
	int                snk_hold_len;
	// bumped by the stimulus for every hold request
	int unsigned       snk_hold_seq;
	int unsigned       cycle_cnt;

	black_point_levels_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels),
		.adjusted  (adjusted),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
	end
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: a hang or a lost word ends the run here
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: check every accepted word, then decide ready for the next cycle
	// one nonblocking write of ready per edge, stall bursts and the long hold
	// are both counted here
	initial begin : receiver
		int stall_left;
		int unsigned hold_seen;
		pix_word_t got;
		stall_left = 0;
		hold_seen  = 0;
		adjusted.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (adjusted.valid && adjusted.ready) begin
				got.red        = adjusted.red_out;
				got.green      = adjusted.green_out;
				got.blue       = adjusted.blue_out;
				got.alpha      = adjusted.alpha_out;
				got.last_pixel = adjusted.last_pixel_out;
				sb.check_pixel(got);
			end
			if (snk_hold_seq != hold_seen) begin
				// long hold so the unit fills up and drops pixels.ready
				stall_left = snk_hold_len;
				hold_seen  = snk_hold_seq;
			end
			if (!arst_n) begin
				adjusted.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				adjusted.ready <= 1'b0;
			end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
				// stall burst, this cycle included
				stall_left = $urandom_range(1, 10) - 1;
				adjusted.ready <= 1'b0;
			end else begin
				adjusted.ready <= 1'b1;
			end
		end
	end

	// channel value with extra weight on the ends of the range
	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pix_word_t random_pixel();
		pix_word_t p;
		p.red        = pick_channel();
		p.green      = pick_channel();
		p.blue       = pick_channel();
		p.alpha      = 8'($urandom_range(0, 255));
		p.last_pixel = ($urandom_range(0, 15) == 0);
		return p;
	endfunction

	// offer one word, hold it until accepted, maybe idle afterwards
	// valid stays high between back-to-back words
	task automatic send_pixel(input pix_word_t p);
		pixels.valid         <= 1'b1;
		pixels.red_in        <= p.red;
		pixels.green_in      <= p.green;
		pixels.blue_in       <= p.blue;
		pixels.alpha_in      <= p.alpha;
		pixels.last_pixel_in <= p.last_pixel;
		do begin
			@(posedge clk);
		end while (!pixels.ready);
		sb.note_pixel(p);
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			pixels.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// stop offering and wait until every predicted word has come back
	task automatic drain();
		pixels.valid <= 1'b0;
		while (sb.expected_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// weight write, only with the unit empty; it then rebuilds its tables
	// and holds pixels.ready low on its own
	task automatic write_weight(input logic signed [9:0] w);
		drain();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.weight = w;
	endtask

	initial begin : stimulus
		// corner pixels shared by all directed weights: all-zero, all-full with last
		// set, one off the ends, values around the black level of the top weight, and mid-scale
		pix_word_t corner_px[5];
		logic signed [9:0] corner_w[5];
		logic signed [9:0] rand_w[RAND_PHASES];
		int ph;
		int k;

		sb           = new();
		src_idle_en  = 1'b1;
		snk_idle_en  = 1'b1;
		snk_hold_len = 0;
		snk_hold_seq = 0;

		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_wdata            <= '0;
		pixels.valid         <= 1'b0;
		pixels.red_in        <= '0;
		pixels.green_in      <= '0;
		pixels.blue_in       <= '0;
		pixels.alpha_in      <= '0;
		pixels.last_pixel_in <= 1'b0;

		corner_px[0] = '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0};
		corner_px[1] = '{8'd255, 8'd255, 8'd255, 8'd255, 1'b1};
		corner_px[2] = '{8'd1,   8'd254, 8'd128, 8'hAA,  1'b0};
		corner_px[3] = '{8'd203, 8'd204, 8'd100, 8'h55,  1'b1};
		corner_px[4] = '{8'd127, 8'd128, 8'd26,  8'd1,   1'b0};

		// pass-through, both mode extremes beyond the nominal range, nominal extremes
		corner_w[0] = 10'sd0;
		corner_w[1] = 10'sd511;
		corner_w[2] = -10'sd512;
		corner_w[3] = 10'sd256;
		corner_w[4] = -10'sd256;

		rand_w[0] = 10'sd1;
		rand_w[1] = -10'sd1;
		rand_w[2] = 10'sd255;
		rand_w[3] = -10'sd255;
		rand_w[4] = 10'($urandom_range(1, 511));
		rand_w[5] = -10'sd511;
		rand_w[6] = 10'($urandom_range(0, 1023));
		rand_w[7] = 10'($urandom_range(0, 1023));
		rand_w[8] = 10'($urandom_range(0, 1023));
		rand_w[9] = 10'($urandom_range(0, 1023));

		// single reset, then the unit builds its tables by itself
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners, weight 0 first as it is the reset value
		for (ph = 0; ph < 5; ph++) begin
			if (ph != 0) begin
				write_weight(corner_w[ph]);
			end
			for (k = 0; k < 5; k++) begin
				send_pixel(corner_px[k]);
			end
		end

		// random words under a range of weights
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			write_weight(rand_w[ph]);
			if (ph == RAND_PHASES - 1) begin
				// closing stretch at full rate on both sides
				src_idle_en = 1'b0;
				snk_idle_en = 1'b0;
			end
			for (k = 0; k < PHASE_WORDS; k++) begin
				if (ph == 2 && k == 20) begin
					// receiver backs off while words keep coming
					snk_hold_len = 80;
					snk_hold_seq++;
				end
				if (ph == 4 && k == PHASE_WORDS / 2) begin
					// sender pauses until the unit is empty, then resumes
					drain();
				end
				send_pixel(random_pixel());
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.expected_q.size() != 0) begin
			sb.report_mismatch("words never returned", 0, sb.expected_q.size());
		end
		if (sb.mismatch_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
